/* hw/rtl/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat send window
// Slot record, request and result items, state codes, command kinds and
// configuration register indexes.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // window geometry
  localparam int WINDOW = 8;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // segment offsets count 512 byte units
  localparam int OFFSET_UNIT  = 512;
  localparam int OFFSET_SHIFT = $clog2(OFFSET_UNIT);
  localparam int SEG_MAX_CAP  = 1024;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  // controller states, also used as the step phase
  localparam int          STATE_W   = 3;
  localparam logic [2:0]  ST_IDLE   = 3'd0;
  localparam logic [2:0]  ST_FILL   = 3'd1;
  localparam logic [2:0]  ST_RESEND = 3'd2;
  localparam logic [2:0]  ST_ACK    = 3'd3;
  localparam logic [2:0]  ST_FINISH = 3'd4;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_SEND      = 3'd1;
  localparam logic [2:0] KIND_RESEND    = 3'd2;
  localparam logic [2:0] KIND_ACK_FREED = 3'd3;
  localparam logic [2:0] KIND_UNMATCHED = 3'd4;

  // configuration register indexes
  localparam int         CFG_IDX_W         = 3;
  localparam logic [2:0] CFG_INITIAL_SEQ   = 3'd0;
  localparam logic [2:0] CFG_TOTAL_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_SEGMENT_MAX   = 3'd2;
  localparam logic [2:0] CFG_SEQ_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd4;

  // one request
  typedef struct packed {
    logic        operation;
    logic [15:0] ack_number;
    logic [15:0] ack_offset;
  } req_item_t;

  // one result
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] seq_number;
    logic [15:0] segment_offset;
    logic [10:0] segment_length;
    logic        all_done;
    logic        last;
  } rsp_item_t;

  // contents of one window slot
  typedef struct packed {
    logic        busy;
    logic        fresh;
    logic [15:0] seq;
    logic [15:0] offset;
    logic [10:0] length;
    logic [15:0] age;
  } slot_rec_t;

  // controller to step unit
  typedef struct packed {
    logic [STATE_W-1:0] phase;
    logic               can_fill;
    logic [15:0]        fill_seq;
    logic [15:0]        fill_offset;
    logic [10:0]        fill_length;
    logic [15:0]        timeout;
    logic [15:0]        ack_number;
    logic [15:0]        ack_offset;
    logic               hit_found;
  } step_ctx_t;

  // step unit to controller
  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic       filled;
    logic       hit;
    logic       busy_after;
  } step_res_t;

endpackage

/* hw/rtl/selective_repeat_send_window_core.sv */
// ----------------------------------------------------------------------------
// selective_repeat_send_window_core: sender window, ring of WINDOW slot cells
// Ack: one pass over the ring, then the final result; a new request is taken only in idle.
// Tick: a fill pass and a resend pass over the ring, then the final result; a
// result that finds the output stalled holds the ring for every stalled cycle.
// Sync reset frees all slots, zeroes counters, loads register defaults.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_core (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               req_valid,
  output logic                               req_stall,
  input  srsw_pkg::req_item_t                req_item,
  // result channel
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output srsw_pkg::rsp_item_t                rsp_item,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  // configuration registers
  logic [15:0] initial_seq;
  logic [31:0] total_length;
  logic [10:0] segment_max;
  logic [15:0] seq_limit;
  logic [15:0] timeout_ticks;

  // transfer state
  logic [15:0] running_seq;
  logic [31:0] bytes_sent;

  // controller
  logic [srsw_pkg::STATE_W-1:0] state;
  logic [srsw_pkg::IDX_W-1:0]   idx;
  srsw_pkg::req_item_t          req_q;
  logic                         hit_found;
  logic                         busy_any;
  logic                         pend_valid;
  srsw_pkg::rsp_item_t          pend_item;

  // ring and step
  srsw_pkg::slot_rec_t cell_rec [srsw_pkg::WINDOW];
  srsw_pkg::slot_rec_t rec_next;
  srsw_pkg::step_ctx_t ctx;
  srsw_pkg::step_res_t step;

  // fill arithmetic
  logic        can_fill;
  logic [31:0] left;
  logic [10:0] segmax_eff;
  logic [10:0] fill_len;
  logic [15:0] seq_base;
  logic [16:0] seq_sum;
  logic [15:0] fill_seq;

  // handshake and flow
  logic                accept;
  logic                in_pass;
  logic                out_free;
  logic                advance;
  logic                shift;
  logic                last_idx;
  logic                push;
  logic                done_flag;
  srsw_pkg::rsp_item_t push_item;
  srsw_pkg::rsp_item_t step_item;
  srsw_pkg::rsp_item_t final_item;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != srsw_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_seq   <= 16'd0;
      total_length  <= 32'd0;
      segment_max   <= 11'd512;
      seq_limit     <= 16'd25600;
      timeout_ticks <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srsw_pkg::CFG_INITIAL_SEQ:   initial_seq   <= cfg_data[15:0];
        srsw_pkg::CFG_TOTAL_LENGTH:  total_length  <= cfg_data;
        srsw_pkg::CFG_SEGMENT_MAX:   segment_max   <= cfg_data[10:0];
        srsw_pkg::CFG_SEQ_LIMIT:     seq_limit     <= cfg_data[15:0];
        srsw_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // next segment length, sequence and offset
  always_comb begin
    can_fill = (bytes_sent < total_length);
    left     = total_length - bytes_sent;
    if (segment_max == 11'd0) begin
      segmax_eff = 11'd1;
    end else if (segment_max > 11'(srsw_pkg::SEG_MAX_CAP)) begin
      segmax_eff = 11'(srsw_pkg::SEG_MAX_CAP);
    end else begin
      segmax_eff = segment_max;
    end
    fill_len = (left < 32'(segmax_eff)) ? left[10:0] : segmax_eff;
    seq_base = (bytes_sent == 32'd0) ? initial_seq : running_seq;
    seq_sum  = {1'b0, seq_base} + 17'(fill_len);
    fill_seq = (seq_sum > {1'b0, seq_limit}) ? 16'(fill_len) : seq_sum[15:0];
  end

  // step context
  always_comb begin
    ctx.phase       = state;
    ctx.can_fill    = can_fill;
    ctx.fill_seq    = fill_seq;
    ctx.fill_offset = bytes_sent[srsw_pkg::OFFSET_SHIFT +: 16];
    ctx.fill_length = fill_len;
    ctx.timeout     = timeout_ticks;
    ctx.ack_number  = req_q.ack_number;
    ctx.ack_offset  = req_q.ack_offset;
    ctx.hit_found   = hit_found;
  end

  srsw_step u_step (
    .ctx      (ctx),
    .head     (cell_rec[0]),
    .rec_next (rec_next),
    .res      (step)
  );

  // ring of slot cells, head record returns at the tail
  for (genvar i = 0; i < srsw_pkg::WINDOW; i++) begin : g_cell
    if (i == srsw_pkg::WINDOW - 1) begin : g_tail
      srsw_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .rec_in (rec_next),
        .rec    (cell_rec[i])
      );
    end else begin : g_body
      srsw_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .rec_in (cell_rec[i+1]),
        .rec    (cell_rec[i])
      );
    end
  end

  // flow control of the passes
  always_comb begin
    in_pass  = (state == srsw_pkg::ST_FILL) || (state == srsw_pkg::ST_RESEND) ||
               (state == srsw_pkg::ST_ACK);
    out_free = !rsp_valid || !rsp_stall;
    advance  = in_pass && !(step.emit && pend_valid && !out_free);
    shift    = advance;
    last_idx = (idx == srsw_pkg::IDX_W'(srsw_pkg::WINDOW - 1));
    done_flag = !can_fill && !busy_any;
  end

  // result of the head slot
  always_comb begin
    step_item.kind           = step.kind;
    step_item.slot           = 3'(idx);
    step_item.seq_number     = rec_next.seq;
    step_item.segment_offset = rec_next.offset;
    step_item.segment_length = rec_next.length;
    step_item.all_done       = 1'b0;
    step_item.last           = 1'b0;
  end

  // final result of a step: held one, unmatched ack or quiet tick
  always_comb begin
    if (pend_valid) begin
      final_item = pend_item;
    end else if (req_q.operation == srsw_pkg::OP_ACK) begin
      final_item.kind           = srsw_pkg::KIND_UNMATCHED;
      final_item.slot           = 3'd0;
      final_item.seq_number     = req_q.ack_number;
      final_item.segment_offset = req_q.ack_offset;
      final_item.segment_length = 11'd0;
    end else begin
      final_item.kind           = srsw_pkg::KIND_NONE;
      final_item.slot           = 3'd0;
      final_item.seq_number     = 16'd0;
      final_item.segment_offset = 16'd0;
      final_item.segment_length = 11'd0;
    end
    final_item.all_done = done_flag;
    final_item.last     = 1'b1;
  end

  // transfer into the output register
  always_comb begin
    if (state == srsw_pkg::ST_FINISH) begin
      push      = out_free;
      push_item = final_item;
    end else begin
      push      = advance && step.emit && pend_valid;
      push_item = pend_item;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= srsw_pkg::ST_IDLE;
      idx        <= '0;
      hit_found  <= 1'b0;
      busy_any   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        srsw_pkg::ST_IDLE: begin
          if (accept) begin
            state     <= (req_item.operation == srsw_pkg::OP_ACK) ?
                         srsw_pkg::ST_ACK : srsw_pkg::ST_FILL;
            idx       <= '0;
            hit_found <= 1'b0;
            busy_any  <= 1'b0;
          end
        end
        srsw_pkg::ST_FILL, srsw_pkg::ST_RESEND, srsw_pkg::ST_ACK: begin
          if (advance) begin
            idx <= last_idx ? '0 : idx + srsw_pkg::IDX_W'(1);
            if (step.hit) begin
              hit_found <= 1'b1;
            end
            if (step.emit) begin
              pend_valid <= 1'b1;
            end
            if (last_idx && (state == srsw_pkg::ST_FILL)) begin
              state    <= srsw_pkg::ST_RESEND;
              busy_any <= 1'b0;
            end else begin
              busy_any <= busy_any | step.busy_after;
              if (last_idx) begin
                state <= srsw_pkg::ST_FINISH;
              end
            end
          end
        end
        srsw_pkg::ST_FINISH: begin
          if (out_free) begin
            state      <= srsw_pkg::ST_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          state <= srsw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // request and held result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_item;
    end
    if (advance && step.emit) begin
      pend_item <= step_item;
    end
  end

  // segment counters
  always_ff @(posedge clk) begin
    if (rst) begin
      running_seq <= 16'd0;
      bytes_sent  <= 32'd0;
    end else if (advance && step.filled) begin
      running_seq <= fill_seq;
      bytes_sent  <= bytes_sent + 32'(fill_len);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_item <= push_item;
    end
  end

`ifndef SYNTHESIS
  // nothing is held back once the block is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == srsw_pkg::ST_IDLE) |-> (!pend_valid && (idx == '0)))
    else $error("held result or slot index left over in idle");

  // byte count moves only during the fill pass
  assert property (@(posedge clk) disable iff (rst)
    (state != srsw_pkg::ST_FILL) |=> $stable(bytes_sent))
    else $error("bytes_sent changed outside the fill pass");

  // a final result always closes the step
  assert property (@(posedge clk) disable iff (rst)
    (push && push_item.last) |=> (state == srsw_pkg::ST_IDLE))
    else $error("final result transfer without return to idle");

  // a send or resend leaves a busy slot, so the transfer is not done
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && ((rsp_item.kind == srsw_pkg::KIND_SEND) ||
                   (rsp_item.kind == srsw_pkg::KIND_RESEND))) |-> !rsp_item.all_done)
    else $error("send or resend reported with all_done set");

  // an ack frees at most one slot
  assert property (@(posedge clk) disable iff (rst)
    (advance && step.hit) |-> !hit_found)
    else $error("second slot freed by one acknowledgement");
`endif

endmodule

/* hw/rtl/srsw_cell.sv */
// ----------------------------------------------------------------------------
// srsw_cell: one slot register of the window ring
// Holds one slot record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module srsw_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  srsw_pkg::slot_rec_t rec_in,
  output srsw_pkg::slot_rec_t rec
);

  // flags are cleared by reset, the whole record moves on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      rec.busy  <= 1'b0;
      rec.fresh <= 1'b0;
    end else if (shift) begin
      rec <= rec_in;
    end
  end

endmodule

/* hw/rtl/srsw_step.sv */
// ----------------------------------------------------------------------------
// srsw_step: update of the slot record at the head of the ring
// Ages and fills in the fill pass, resends in the resend pass and matches
// acknowledgements in the ack pass.
// ----------------------------------------------------------------------------
module srsw_step (
  input  srsw_pkg::step_ctx_t ctx,
  input  srsw_pkg::slot_rec_t head,
  output srsw_pkg::slot_rec_t rec_next,
  output srsw_pkg::step_res_t res
);

  always_comb begin
    rec_next   = head;
    res.emit   = 1'b0;
    res.kind   = srsw_pkg::KIND_NONE;
    res.filled = 1'b0;
    res.hit    = 1'b0;
    case (ctx.phase)
      srsw_pkg::ST_FILL: begin
        // age a busy slot, fill a free one while bytes remain
        if (head.busy) begin
          if (head.age != srsw_pkg::AGE_MAX) begin
            rec_next.age = head.age + 16'd1;
          end
        end else if (ctx.can_fill) begin
          rec_next.busy   = 1'b1;
          rec_next.fresh  = 1'b1;
          rec_next.seq    = ctx.fill_seq;
          rec_next.offset = ctx.fill_offset;
          rec_next.length = ctx.fill_length;
          rec_next.age    = 16'd0;
          res.emit        = 1'b1;
          res.kind        = srsw_pkg::KIND_SEND;
          res.filled      = 1'b1;
        end
      end
      srsw_pkg::ST_RESEND: begin
        // slots filled in this tick are skipped
        rec_next.fresh = 1'b0;
        if (head.busy && !head.fresh && (head.age > ctx.timeout)) begin
          rec_next.age = 16'd0;
          res.emit     = 1'b1;
          res.kind     = srsw_pkg::KIND_RESEND;
        end
      end
      srsw_pkg::ST_ACK: begin
        // first busy slot with matching sequence and offset is freed
        if (!ctx.hit_found && head.busy && (head.seq == ctx.ack_number) &&
            (head.offset == ctx.ack_offset)) begin
          rec_next.busy = 1'b0;
          res.emit      = 1'b1;
          res.kind      = srsw_pkg::KIND_ACK_FREED;
          res.hit       = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.busy_after = rec_next.busy;
  end

endmodule
